// ===== rtl/core/isort_pkg.sv =====
// Shared constants and types for the insertion sorter.
package isort_pkg;

  // Number of cells in the sorting chain
  localparam int unsigned Depth = 16;

  // Width of one sorted element
  localparam int unsigned ValueW = 32;

  // State one cell shows to its neighbours
  typedef struct packed {
    logic                     occ;
    logic                     gt;
    logic signed [ValueW-1:0] value;
  } cell_t;

endpackage

// ===== rtl/core/isort_if.sv =====
// Request channels of the insertion sorter: input elements and sorted results.
interface is_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [isort_pkg::ValueW-1:0]  value;
  logic                                 last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

interface is_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [isort_pkg::ValueW-1:0]  value_res;
  logic                                 last_res;
  logic                                 overflow;

  modport source (output valid, output value_res, output last_res, output overflow,
                  input ready);
  modport sink (input valid, input value_res, input last_res, input overflow,
                output ready);
endinterface

// ===== rtl/core/isort_cell.sv =====
// One cell of the sorting chain: holds a value, inserts in place, drains leftwards.
module isort_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                ins_i,
  input  logic                                shift_i,
  input  logic signed [isort_pkg::ValueW-1:0] val_i,
  input  isort_pkg::cell_t                    left_i,
  input  isort_pkg::cell_t                    right_i,
  output isort_pkg::cell_t                    state_o
);

  logic                                occ_q, occ_d;
  logic signed [isort_pkg::ValueW-1:0] value_q, value_d;
  logic                                gt;

  // Stored value lies strictly above the incoming one: it must move right
  assign gt = occ_q && (value_q > val_i);

  // Insert: shift right past larger values, or take the new value in place; on drain, take the right neighbour's state
  always_comb begin
    occ_d   = occ_q;
    value_d = value_q;
    if (shift_i) begin
      occ_d   = right_i.occ;
      value_d = right_i.value;
    end else if (ins_i) begin
      occ_d = occ_q | left_i.occ;
      if (gt || (!occ_q && left_i.occ)) begin
        value_d = left_i.gt ? left_i.value : val_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // Payload holds no reset
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign state_o = '{occ: occ_q, gt: gt, value: value_q};

endmodule

// ===== rtl/core/insertion_sorter.sv =====
// Insertion sorter: accepts one element per cycle while filling, then drains the batch in order.
// Order: an element is inserted in the cycle it is accepted; after the last one the
// drain flag is registered, then results leave the head cell, one per cycle while taken.
// Input: one element per cycle while filling; input stalls while the chain drains.
// Reset clears occupancy and control flags; the result registers hold no reset.
module insertion_sorter (
  input  logic        clk_i,
  input  logic        rst_ni,
  is_in_if.sink       in_i,
  is_out_if.source    out_o
);

  localparam int unsigned Depth = isort_pkg::Depth;

  isort_pkg::cell_t cells [Depth];
  isort_pkg::cell_t lefts [Depth];
  isort_pkg::cell_t rights [Depth];
  logic [Depth-1:0] occ;

  logic draining_q, draining_d;
  logic dropped_q, dropped_d;
  logic out_valid_q, out_valid_d;
  logic signed [isort_pkg::ValueW-1:0] value_res_q;
  logic last_res_q;
  logic overflow_q;

  logic accept, full, ins, adv, drain_end;

  // Input stalls only while the chain drains
  assign in_i.ready = !draining_q;
  assign accept     = in_i.valid && in_i.ready;
  assign full       = occ[Depth-1];
  assign ins        = accept && !full;
  assign adv        = draining_q && (!out_valid_q || out_o.ready);
  assign drain_end  = adv && !occ[1];

  // Build the chain of cells
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign lefts[i] = '{occ: 1'b1, gt: 1'b0, value: '0};
    end else begin : g_mid
      assign lefts[i] = cells[i-1];
    end
    if (i == Depth - 1) begin : g_end
      assign rights[i] = '0;
    end else begin : g_inner
      assign rights[i] = cells[i+1];
    end
    isort_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ins_i   (ins),
      .shift_i (adv),
      .val_i   (in_i.value),
      .left_i  (lefts[i]),
      .right_i (rights[i]),
      .state_o (cells[i])
    );
    assign occ[i] = cells[i].occ;
  end

  // Control: start draining after the last element, stop when the chain empties; flag elements dropped while full
  always_comb begin
    draining_d = draining_q;
    dropped_d  = dropped_q;
    if (accept && full) begin
      dropped_d = 1'b1;
    end
    if (accept && in_i.last) begin
      draining_d = 1'b1;
    end else if (drain_end) begin
      draining_d = 1'b0;
      dropped_d  = 1'b0;
    end
  end

  // Output register: load from the head cell, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      draining_q  <= 1'b0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      draining_q  <= draining_d;
      dropped_q   <= dropped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      value_res_q <= cells[0].value;
      last_res_q  <= !occ[1];
      overflow_q  <= dropped_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.value_res = value_res_q;
  assign out_o.last_res  = last_res_q;
  assign out_o.overflow  = overflow_q;

  // Adjacent occupied cells are in ascending order
  logic [Depth-1:0] order_ok;
  assign order_ok[0] = 1'b1;
  for (genvar i = 1; i < Depth; i++) begin : g_chk
    assign order_ok[i] = !occ[i] || (cells[i-1].value <= cells[i].value);
  end

`ifndef SYNTHESIS
  a_occ_prefix : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((occ + 1'b1) & occ) == '0)
    else $error("occupied cells not contiguous from the head");

  a_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    &order_ok)
    else $error("chain not in ascending order");

  a_drain_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(draining_q) |-> occ[0])
    else $error("drain started on an empty chain");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=>
      (out_valid_q && $stable(value_res_q) && $stable(last_res_q) &&
       $stable(overflow_q)))
    else $error("stalled result changed before it was taken");
`endif

endmodule
